// ===== hw/rtl/kmds_pkg.sv =====
// Shared types and constants for the key matrix debounce scanner.
// No dependencies; imported by every module of the block.
package kmds_pkg;

	// Default matrix geometry
	localparam int ROWS_DEF = 4;
	localparam int COLS_DEF = 6;

	// Field widths
	localparam int COLUMN_W   = 3;
	localparam int ROW_BITS_W = 4;
	localparam int KEY_ROW_W  = 2;
	localparam int COUNT_W    = 2;
	localparam int MASK_W     = 24;
	localparam int MASK_IDX_W = 5;
	// Holds row*COLS+column for the largest legal geometry
	localparam int POS_W      = 7;
	localparam int REG_IDX_W  = 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX     = 2'd3;
	localparam logic [MASK_W-1:0]  MASK_RESET    = 24'h1FFFFF;
	localparam logic [COUNT_W-1:0] THRESH_RESET  = 2'd2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_EMIT_MASK = 1'b0,
		REG_THRESHOLD = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [COLUMN_W-1:0]   column;
		logic [ROW_BITS_W-1:0] row_bits;
		logic                  read_ok;
	} in_item_t;

	typedef struct packed {
		logic [KEY_ROW_W-1:0] key_row;
		logic [COLUMN_W-1:0]  key_column;
		logic                 pressed;
		logic                 last;
	} out_item_t;

	// Per-lane debounce result
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               stable;
		logic               event_hit;
	} lane_out_t;

endpackage

// ===== hw/rtl/kmds_lane.sv =====
// One row lane of the debounce scanner: counter and stable-bit update for one key.
// Depends on kmds_pkg.
module kmds_lane #(
	parameter int ROW  = 0,
	parameter int COLS = kmds_pkg::COLS_DEF
) (
	input  logic                          raw,
	input  logic                          prev,
	input  logic                          stab,
	input  logic [kmds_pkg::COUNT_W-1:0]  count,
	input  logic [kmds_pkg::COUNT_W-1:0]  threshold,
	input  logic [kmds_pkg::COLUMN_W-1:0] column,
	input  logic [kmds_pkg::MASK_W-1:0]   emit_mask,
	output kmds_pkg::lane_out_t           result
);
	import kmds_pkg::*;

	logic [COUNT_W-1:0] count_n;
	logic               change;
	logic [POS_W-1:0]   pos;
	logic               enabled;

	always_comb begin
		if (raw == prev) begin
			count_n = (count == COUNT_MAX) ? COUNT_MAX : count + 1'b1;
		end else begin
			count_n = '0;
		end
		change = (count_n >= threshold) && (raw != stab);

		// key position row*COLS+column; bits past the mask width are disabled
		pos = POS_W'(ROW * COLS) + POS_W'(column);
		if (pos < POS_W'(MASK_W)) begin
			enabled = emit_mask[pos[MASK_IDX_W-1:0]];
		end else begin
			enabled = 1'b0;
		end

		result.count     = count_n;
		result.stable    = change ? raw : stab;
		result.event_hit = change && enabled;
	end

endmodule

// ===== hw/rtl/kmds_merge.sv =====
// Merge stage: holds the lane event flags of one item and serializes them in row order.
// Depends on kmds_pkg.
module kmds_merge #(
	parameter int ROWS = kmds_pkg::ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [ROWS-1:0]               events,
	input  logic [ROWS-1:0]               raw_bits,
	input  logic [kmds_pkg::COLUMN_W-1:0] column,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output kmds_pkg::out_item_t           out_data
);
	import kmds_pkg::*;

	localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [ROWS-1:0]      pend_q;
	logic [ROWS-1:0]      press_q;
	logic [COLUMN_W-1:0]  col_q;
	logic [ROWS-1:0]      low_bit;
	logic [ROWS-1:0]      rest;
	logic [ROW_IDX_W-1:0] sel_idx;
	logic                 found;

	always_comb begin
		sel_idx = '0;
		found   = 1'b0;
		for (int i = 0; i < ROWS; i++) begin
			if (!found && pend_q[i]) begin
				sel_idx = ROW_IDX_W'(i);
				found   = 1'b1;
			end
		end
		low_bit = pend_q & (~pend_q + 1'b1);
		rest    = pend_q & ~low_bit;
	end

	assign out_valid = (pend_q != '0);
	// take a new item once the last pending event leaves this cycle
	assign in_ready  = (pend_q == '0) || ((rest == '0) && out_ready);

	always_comb begin
		out_data.key_row    = KEY_ROW_W'(sel_idx);
		out_data.key_column = col_q;
		out_data.pressed    = press_q[sel_idx];
		out_data.last       = (rest == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= events;
		end else if (out_valid && out_ready) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			press_q <= raw_bits;
			col_q   <= column;
		end
	end

endmodule

// ===== hw/rtl/key_matrix_debounce_scanner_top.sv =====
// Top level of the key matrix debounce scanner: per-key state, row lanes, merge stage.
// Depends on kmds_pkg, kmds_lane and kmds_merge.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one scanned column: its index,
//   the raw row sense bits and a read_ok flag. Each row of that column is debounced
//   by its own lane in the transfer cycle; key state is updated at that edge.
//   Output channel (out_valid/out_ready/out_data) carries one key event per transfer:
//   row, column, new stable level and a last flag on the final event of an item.
//   Events leave in ascending row order, only for positions set in emit_mask.
//   Latency: first event is offered the cycle after the input transfer.
//   Throughput: a new item is taken in the cycle its predecessor's last event
//   transfers, so items without events go back to back at one per cycle.
//   A failed read or a column index at or above COLS updates nothing, emits nothing.
//   Receiver stall: out_data holds and in_ready drops while more than one event,
//   or an untaken final event, is pending.
//   Reset: all keys released, raw history and counters zero, emit_mask 0x1FFFFF,
//   debounce_threshold 2. Config writes (cfg_we) take effect at the next edge and
//   must only be issued while the block is idle.
module key_matrix_debounce_scanner_top #(
	parameter int ROWS = kmds_pkg::ROWS_DEF,
	parameter int COLS = kmds_pkg::COLS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  kmds_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output kmds_pkg::out_item_t            out_data,
	input  logic                           cfg_we,
	input  logic [kmds_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [kmds_pkg::MASK_W-1:0]    cfg_data
);
	import kmds_pkg::*;

	localparam int COL_IDX_W = (COLS > 1) ? $clog2(COLS) : 1;

	// configuration
	logic [MASK_W-1:0]  emit_mask_q;
	logic [COUNT_W-1:0] thresh_q;

	// per-key state: stable and last raw bits by column, counters by lane
	logic [ROWS-1:0]    stable_q   [COLS];
	logic [ROWS-1:0]    last_raw_q [COLS];
	logic [COUNT_W-1:0] count_q    [ROWS][COLS];

	logic                 in_xfer;
	logic                 item_ok;
	logic [COL_IDX_W-1:0] col_idx;
	logic [ROWS-1:0]      raw_vec;
	logic [ROWS-1:0]      stab_vec;
	logic [ROWS-1:0]      event_vec;
	lane_out_t            lane_res [ROWS];

	assign in_xfer = in_valid && in_ready;
	assign item_ok = in_data.read_ok && (int'(in_data.column) < COLS);
	assign col_idx = COL_IDX_W'(in_data.column);

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_mask_q <= MASK_RESET;
			thresh_q    <= THRESH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_EMIT_MASK: emit_mask_q <= cfg_data;
				REG_THRESHOLD: thresh_q    <= cfg_data[COUNT_W-1:0];
			endcase
		end
	end

	// one lane per row; rows beyond the sensed bits read as released
	for (genvar r = 0; r < ROWS; r++) begin : g_lane
		if (r < ROW_BITS_W) begin : g_raw
			assign raw_vec[r] = in_data.row_bits[r];
		end else begin : g_zero
			assign raw_vec[r] = 1'b0;
		end

		kmds_lane #(
			.ROW  (r),
			.COLS (COLS)
		) u_lane (
			.raw       (raw_vec[r]),
			.prev      (last_raw_q[col_idx][r]),
			.stab      (stable_q[col_idx][r]),
			.count     (count_q[r][col_idx]),
			.threshold (thresh_q),
			.column    (in_data.column),
			.emit_mask (emit_mask_q),
			.result    (lane_res[r])
		);

		assign stab_vec[r]  = lane_res[r].stable;
		assign event_vec[r] = lane_res[r].event_hit && item_ok;
	end

	// state write-back at the input transfer edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < COLS; c++) begin
				stable_q[c]   <= '0;
				last_raw_q[c] <= '0;
				for (int r = 0; r < ROWS; r++) begin
					count_q[r][c] <= '0;
				end
			end
		end else if (in_xfer && item_ok) begin
			stable_q[col_idx]   <= stab_vec;
			last_raw_q[col_idx] <= raw_vec;
			for (int r = 0; r < ROWS; r++) begin
				count_q[r][col_idx] <= lane_res[r].count;
			end
		end
	end

	kmds_merge #(
		.ROWS (ROWS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_xfer),
		.events    (event_vec),
		.raw_bits  (raw_vec),
		.column    (in_data.column),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a failed read never produces an event
	a_fail_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !in_data.read_ok) |=> !out_valid)
		else $error("event after failed read");

	// nothing pending means the input side is open
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no pending event");

	// more events of the same item still pending keep the input closed
	a_burst_block: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.last) |-> !in_ready)
		else $error("input open mid-burst");

	// final event taken with no new item leaves the output empty
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_data.last && !in_valid) |=> !out_valid)
		else $error("output still valid after final event");

endmodule
